[hw/rtl/xtea_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// XTEA decrypt package
// Shared word and key types, stage bus, cipher constants and the mix function.
// ----------------------------------------------------------------------------
package xtea_pkg;

  localparam int WORD_W    = 32;
  localparam int KEY_WORDS = 4;
  localparam int CFG_ADDR_W = 8;

  typedef logic [WORD_W-1:0]                word_t;
  typedef logic [KEY_WORDS-1:0][WORD_W-1:0] key_t;
  typedef logic [CFG_ADDR_W-1:0]            cfg_addr_t;

  // Register indexes on the config port
  localparam cfg_addr_t KEY_IDX_0 = 8'd0;
  localparam cfg_addr_t KEY_IDX_1 = 8'd1;
  localparam cfg_addr_t KEY_IDX_2 = 8'd2;
  localparam cfg_addr_t KEY_IDX_3 = 8'd3;

  // Round constant
  localparam word_t XTEA_DELTA = 32'h9E37_79B9;

  // One block moving down the pipeline
  typedef struct packed {
    logic  valid;
    word_t left;
    word_t right;
  } blk_t;

  // ((x << 4) ^ (x >> 5)) + x, wrapping
  function automatic word_t mix_word(input word_t x);
    mix_word = ((x << 4) ^ (x >> 5)) + x;
  endfunction

endpackage

[hw/rtl/xtea_block_decrypt.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// XTEA block decrypt
// Fully unrolled XTEA decryption, one registered stage per half round.
//
//   channel | dir | handshake            | payload
//   in_     | in  | in_tvalid/in_tready  | in_tdata: cipher_left, cipher_right
//   out_    | out | out_tvalid/out_tready| out_tdata: plain_left, plain_right
//   cfg_    | in  | cfg_valid/cfg_ready  | cfg_addr (key word index), cfg_data
//
// One word accepted per cycle while the output is not stalled; the pipeline has
// one registered stage per half round, since each half round is an add/xor/subtract chain on 32 bits.
// Reset clears the stage valid bits and the key words to zero.
// A stall at the output freezes the whole pipeline; in_tready follows
// out_tready whenever the last stage holds a word. cfg_ready is always high.
// ----------------------------------------------------------------------------
module xtea_block_decrypt #(
  parameter int ROUNDS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  // tdata: [31:0] cipher_left, [63:32] cipher_right
  input  logic [63:0] in_tdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  // tdata: [31:0] plain_left, [63:32] plain_right
  output logic [63:0] out_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  xtea_pkg::cfg_addr_t cfg_addr,
  input  logic [31:0] cfg_data
);

  localparam int STAGES = 2 * ROUNDS;

  xtea_pkg::key_t key_r;
  xtea_pkg::blk_t stg [0:STAGES];
  logic           en;

  // key registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_addr)
        xtea_pkg::KEY_IDX_0: key_r[0] <= cfg_data;
        xtea_pkg::KEY_IDX_1: key_r[1] <= cfg_data;
        xtea_pkg::KEY_IDX_2: key_r[2] <= cfg_data;
        xtea_pkg::KEY_IDX_3: key_r[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg_ready = 1'b1;

  // pipeline moves when the output slot is free or being drained
  assign en        = out_tready || !stg[STAGES].valid;
  assign in_tready = en;

  assign stg[0].valid = in_tvalid;
  assign stg[0].left  = in_tdata[31:0];
  assign stg[0].right = in_tdata[63:32];

  // half-round stages; stage s uses sum = delta * (ROUNDS - (s+1)/2)
  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    localparam logic [63:0] SUM_FULL =
      64'(xtea_pkg::XTEA_DELTA) * 64'(ROUNDS - (s + 1) / 2);
    xtea_stage #(
      .LEFT_HALF (bit'(s % 2)),
      .SUM       (SUM_FULL[31:0])
    ) u_stage (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .key     (key_r),
      .blk_in  (stg[s]),
      .blk_out (stg[s+1])
    );
  end

  assign out_tvalid = stg[STAGES].valid;
  assign out_tdata  = {stg[STAGES].right, stg[STAGES].left};

endmodule

[hw/rtl/xtea_stage.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// XTEA half-round stage
// One registered half round: updates either the right or the left half with a
// sum value fixed at elaboration, so the key select is a constant.
// ----------------------------------------------------------------------------
module xtea_stage #(
  parameter bit          LEFT_HALF = 1'b0,
  parameter logic [31:0] SUM       = 32'h0000_0000
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  xtea_pkg::key_t key,
  input  xtea_pkg::blk_t blk_in,
  output xtea_pkg::blk_t blk_out
);

  // key word picked by sum bits 1:0 (left) or 12:11 (right)
  localparam logic [1:0] KSEL = LEFT_HALF ? SUM[1:0] : SUM[12:11];

  xtea_pkg::word_t skey;
  xtea_pkg::word_t mix;
  xtea_pkg::word_t left_nxt;
  xtea_pkg::word_t right_nxt;
  logic            valid_r;
  xtea_pkg::word_t left_r;
  xtea_pkg::word_t right_r;

  // half-round datapath
  always_comb begin
    skey = SUM + key[KSEL];
    if (LEFT_HALF) begin
      mix       = xtea_pkg::mix_word(blk_in.right) ^ skey;
      left_nxt  = blk_in.left - mix;
      right_nxt = blk_in.right;
    end else begin
      mix       = xtea_pkg::mix_word(blk_in.left) ^ skey;
      left_nxt  = blk_in.left;
      right_nxt = blk_in.right - mix;
    end
  end

  // valid bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= blk_in.valid;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (en) begin
      left_r  <= left_nxt;
      right_r <= right_nxt;
    end
  end

  assign blk_out.valid = valid_r;
  assign blk_out.left  = left_r;
  assign blk_out.right = right_r;

endmodule

[hw/rtl/xtea_chk.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// XTEA decrypt port checker
// Watches the top-level ports for stall and reset behavior.
// ----------------------------------------------------------------------------
module xtea_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic [63:0] out_tdata,
  input logic        out_tvalid,
  input logic        out_tready
);

  // a stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output word changed while stalled");

  // input side is backpressured exactly when the output is stalled
  a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (out_tready || !out_tvalid))
    else $error("in_tready does not follow output stall");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

endmodule

bind xtea_block_decrypt xtea_chk u_xtea_chk (.*);
